[rtl/i2cmbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Opcodes, phase numbers and the beat types shared by the sequencer modules.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

   localparam int OP_W     = 3;
   localparam int PHASE_W  = 5;
   localparam int TICK_W   = 16;
   localparam int BYTE_W   = 8;

   localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_W-1:0] OP_START = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ  = 3'd4;
   localparam logic [OP_W-1:0] OP_IDLE  = 3'd0;

   // phases of the long (byte) sequences
   localparam logic [PHASE_W-1:0] BYTE_PHASES     = 5'd16;
   localparam logic [PHASE_W-1:0] ACK_HIGH_PHASE  = 5'd17;
   localparam logic [PHASE_W-1:0] LONG_LAST_PHASE = 5'd18;
   localparam logic [PHASE_W-1:0] SHORT_LAST_PHASE = 5'd3;

   localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd1;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [BYTE_W-1:0] data_byte;
      logic              ack_after_read;
      logic              sda_in;
   } req_beat_type;

   typedef struct packed {
      logic              scl_level;
      logic              sda_level;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_byte;
      logic              slave_acked;
      logic              command_rejected;
   } rsp_beat_type;

endpackage
`default_nettype wire

[rtl/i2cmbs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer channels
// Valid/ready channels for commands, results and the phase-length register.
// ----------------------------------------------------------------------------
interface i2cmbs_req_if;
   logic                           valid;
   logic                           ready;
   logic [i2cmbs_pkg::OP_W-1:0]    opcode;
   logic [i2cmbs_pkg::BYTE_W-1:0]  data_byte;
   logic                           ack_after_read;
   logic                           sda_in;

   modport source (output valid, opcode, data_byte, ack_after_read, sda_in,
                   input ready);
   modport sink (input valid, opcode, data_byte, ack_after_read, sda_in,
                 output ready);
endinterface

interface i2cmbs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           scl_level;
   logic                           sda_level;
   logic                           busy_res;
   logic                           done_res;
   logic [i2cmbs_pkg::BYTE_W-1:0]  read_byte;
   logic                           slave_acked;
   logic                           command_rejected;

   modport source (output valid, scl_level, sda_level, busy_res, done_res,
                   read_byte, slave_acked, command_rejected, input ready);
   modport sink (input valid, scl_level, sda_level, busy_res, done_res,
                 read_byte, slave_acked, command_rejected, output ready);
endinterface

interface i2cmbs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [i2cmbs_pkg::TICK_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/i2cmbs_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer input stage
// Registers one command beat and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module i2cmbs_in_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   i2cmbs_req_if.sink                    req_chan,
   input  wire logic                     take,
   output logic                          item_valid,
   output i2cmbs_pkg::req_beat_type      item
);

   logic                     valid_ff;
   logic                     valid_in;
   i2cmbs_pkg::req_beat_type item_ff;
   logic                     load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.opcode         <= req_chan.opcode;
         item_ff.data_byte      <= req_chan.data_byte;
         item_ff.ack_after_read <= req_chan.ack_after_read;
         item_ff.sda_in         <= req_chan.sda_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

[rtl/i2cmbs_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer engine
// Bus state, phase counter and pin levels; one beat is stepped per cycle while the result register has space.
// ----------------------------------------------------------------------------
module i2cmbs_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   i2cmbs_csr_if.sink                    csr_chan,
   input  wire logic                     item_valid,
   input  wire i2cmbs_pkg::req_beat_type item,
   input  wire logic                     space,
   output logic                          take,
   output i2cmbs_pkg::rsp_beat_type      result
);

   logic [i2cmbs_pkg::TICK_W-1:0]  phase_ticks_ff;
   logic [i2cmbs_pkg::OP_W-1:0]    cmd_ff, cmd_in;
   logic [i2cmbs_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [i2cmbs_pkg::TICK_W-1:0]  tick_ff, tick_in;
   logic [i2cmbs_pkg::BYTE_W-1:0]  shift_ff, shift_in;
   logic                           ack_choice_ff, ack_choice_in;
   logic                           ack_seen_ff, ack_seen_in;
   logic                           scl_ff, scl_in;
   logic                           sda_ff, sda_in;

   // pin levels {scl, sda} for a phase of a command
   function automatic logic [1:0] phase_levels(
      input logic [i2cmbs_pkg::OP_W-1:0]    cmd,
      input logic [i2cmbs_pkg::PHASE_W-1:0] ph,
      input logic [i2cmbs_pkg::BYTE_W-1:0]  shift,
      input logic                           ack_choice,
      input logic                           sda_cur
   );
      logic scl;
      logic sda;
      scl = 1'b0;
      sda = sda_cur;
      unique case (cmd)
         i2cmbs_pkg::OP_START: begin
            unique case (ph[1:0])
               2'd0: begin scl = 1'b0; sda = 1'b1; end
               2'd1: begin scl = 1'b1; sda = 1'b1; end
               2'd2: begin scl = 1'b1; sda = 1'b0; end
               default: begin scl = 1'b0; sda = 1'b0; end
            endcase
         end
         i2cmbs_pkg::OP_STOP: begin
            unique case (ph[1:0])
               2'd0: begin scl = 1'b0; sda = sda_cur; end
               2'd1: begin scl = 1'b0; sda = 1'b0; end
               2'd2: begin scl = 1'b1; sda = 1'b0; end
               default: begin scl = 1'b1; sda = 1'b1; end
            endcase
         end
         i2cmbs_pkg::OP_WRITE: begin
            scl = ph[0];
            if (ph < i2cmbs_pkg::BYTE_PHASES) begin
               sda = shift[~ph[3:1]];
            end else if (ph < i2cmbs_pkg::LONG_LAST_PHASE) begin
               sda = 1'b1;
            end else begin
               scl = 1'b0;
               sda = 1'b1;
            end
         end
         i2cmbs_pkg::OP_READ: begin
            scl = ph[0];
            if (ph < i2cmbs_pkg::BYTE_PHASES) begin
               sda = 1'b1;
            end else if (ph < i2cmbs_pkg::LONG_LAST_PHASE) begin
               sda = !ack_choice;
            end else begin
               scl = 1'b0;
               sda = 1'b1;
            end
         end
         default: begin
            scl = 1'b0;
            sda = sda_cur;
         end
      endcase
      return {scl, sda};
   endfunction

   logic                           busy;
   logic                           is_cmd;
   logic                           long_cmd;
   logic [i2cmbs_pkg::TICK_W-1:0]  limit;
   logic [i2cmbs_pkg::TICK_W:0]    tick_next;
   logic [i2cmbs_pkg::PHASE_W-1:0] last_phase;
   logic [i2cmbs_pkg::PHASE_W-1:0] phase_next;
   logic [1:0]                     levels;
   logic                           done;
   logic                           rejected;
   logic [i2cmbs_pkg::BYTE_W-1:0]  rbyte;

   assign csr_chan.ready = 1'b1;
   assign take           = item_valid && space;

   assign busy     = (cmd_ff != i2cmbs_pkg::OP_IDLE);
   assign is_cmd   = (item.opcode == i2cmbs_pkg::OP_START) ||
                     (item.opcode == i2cmbs_pkg::OP_STOP)  ||
                     (item.opcode == i2cmbs_pkg::OP_WRITE) ||
                     (item.opcode == i2cmbs_pkg::OP_READ);
   assign long_cmd = (cmd_ff == i2cmbs_pkg::OP_WRITE) || (cmd_ff == i2cmbs_pkg::OP_READ);
   assign limit    = (phase_ticks_ff == '0) ? i2cmbs_pkg::PHASE_TICKS_RESET : phase_ticks_ff;
   assign tick_next  = {1'b0, tick_ff} + 17'd1;
   assign last_phase = long_cmd ? i2cmbs_pkg::LONG_LAST_PHASE : i2cmbs_pkg::SHORT_LAST_PHASE;
   assign phase_next = phase_ff + 5'd1;

   always_comb begin
      cmd_in        = cmd_ff;
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      shift_in      = shift_ff;
      ack_choice_in = ack_choice_ff;
      ack_seen_in   = ack_seen_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      done          = 1'b0;
      rejected      = 1'b0;
      rbyte         = '0;
      levels        = 2'b00;
      if (is_cmd) begin
         if (busy) begin
            rejected = 1'b1;
         end else begin
            // load a new command and drive its first phase
            cmd_in   = item.opcode;
            phase_in = '0;
            tick_in  = '0;
            if (item.opcode == i2cmbs_pkg::OP_WRITE) begin
               shift_in    = item.data_byte;
               ack_seen_in = 1'b0;
            end else if (item.opcode == i2cmbs_pkg::OP_READ) begin
               shift_in      = '0;
               ack_choice_in = item.ack_after_read;
            end
            levels = phase_levels(item.opcode, '0, shift_in, ack_choice_in, sda_ff);
            scl_in = levels[1];
            sda_in = levels[0];
         end
      end else if (item.opcode == i2cmbs_pkg::OP_TICK && busy) begin
         if (tick_next >= {1'b0, limit}) begin
            tick_in = '0;
            if (cmd_ff == i2cmbs_pkg::OP_WRITE && phase_ff == i2cmbs_pkg::ACK_HIGH_PHASE) begin
               ack_seen_in = !item.sda_in;
            end
            // sample at the end of each SCL-high data phase
            if (cmd_ff == i2cmbs_pkg::OP_READ && phase_ff < i2cmbs_pkg::BYTE_PHASES &&
                phase_ff[0]) begin
               shift_in = {shift_ff[i2cmbs_pkg::BYTE_W-2:0], item.sda_in};
            end
            if (phase_ff == last_phase) begin
               cmd_in   = i2cmbs_pkg::OP_IDLE;
               phase_in = '0;
               done     = 1'b1;
               if (cmd_ff == i2cmbs_pkg::OP_READ) begin
                  rbyte = shift_in;
               end
            end else begin
               phase_in = phase_next;
               levels   = phase_levels(cmd_ff, phase_next, shift_in, ack_choice_ff, sda_ff);
               scl_in   = levels[1];
               sda_in   = levels[0];
            end
         end else begin
            tick_in = tick_next[i2cmbs_pkg::TICK_W-1:0];
         end
      end
   end

   always_comb begin
      result.scl_level        = scl_in;
      result.sda_level        = sda_in;
      result.busy_res         = (cmd_in != i2cmbs_pkg::OP_IDLE);
      result.done_res         = done;
      result.read_byte        = rbyte;
      result.slave_acked      = ack_seen_in;
      result.command_rejected = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cmbs_pkg::PHASE_TICKS_RESET;
      end else if (csr_chan.valid) begin
         phase_ticks_ff <= csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= i2cmbs_pkg::OP_IDLE;
         phase_ff      <= '0;
         tick_ff       <= '0;
         shift_ff      <= '0;
         ack_choice_ff <= 1'b0;
         ack_seen_ff   <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
      end else if (take) begin
         cmd_ff        <= cmd_in;
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         shift_ff      <= shift_in;
         ack_choice_ff <= ack_choice_in;
         ack_seen_ff   <= ack_seen_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
      end
   end

endmodule
`default_nettype wire

[rtl/i2cmbs_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cmbs_out_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire i2cmbs_pkg::rsp_beat_type result,
   output logic                          space,
   i2cmbs_rsp_if.source                  rsp_chan
);

   logic                     valid_ff;
   logic                     valid_in;
   i2cmbs_pkg::rsp_beat_type beat_ff;

   assign space    = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= result;
      end
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.scl_level        = beat_ff.scl_level;
   assign rsp_chan.sda_level        = beat_ff.sda_level;
   assign rsp_chan.busy_res         = beat_ff.busy_res;
   assign rsp_chan.done_res         = beat_ff.done_res;
   assign rsp_chan.read_byte        = beat_ff.read_byte;
   assign rsp_chan.slave_acked      = beat_ff.slave_acked;
   assign rsp_chan.command_rejected = beat_ff.command_rejected;

endmodule
`default_nettype wire

[rtl/i2c_master_bit_sequencer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Command and tick beats in, one pin/status result beat out per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries start, stop, write-byte, read-byte commands and tick
//   beats; each tick advances the current half-bit phase counter, and a
//   phase ends after phase_ticks ticks. Every req beat yields exactly one
//   rsp beat with the SCL/SDA levels and status after that beat.
//   csr_chan writes phase_ticks; it is always ready and should be written
//   only while no beat is in flight.
//   A rsp beat passes through the input register, then the result register,
//   after its req beat is accepted; a stall on rsp_chan can hold it in
//   either. One beat per cycle is sustained while rsp_chan takes its beats:
//   the step is a single pass of counter and phase logic between the two registers.
//   Reset idles the bus with SCL high, SDA released and phase_ticks at 1.
//   When rsp_chan stalls, the result register holds its beat and the input
//   register holds the next one; req_chan ready drops only when both are full.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core (
   input  wire logic     clock,
   input  wire logic     reset,
   i2cmbs_req_if.sink    req_chan,
   i2cmbs_rsp_if.source  rsp_chan,
   i2cmbs_csr_if.sink    csr_chan
);

   logic                     item_valid;
   i2cmbs_pkg::req_beat_type item;
   logic                     take;
   logic                     space;
   i2cmbs_pkg::rsp_beat_type result;

   i2cmbs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cmbs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_chan   (csr_chan),
      .item_valid (item_valid),
      .item       (item),
      .space      (space),
      .take       (take),
      .result     (result)
   );

   i2cmbs_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (take),
      .result   (result),
      .space    (space),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer core testbench
// Drives command and tick beats through the request channel, predicts the
// pin and status beat for every accepted request and checks each result
// beat. A short table of directed beats comes first, then random
// well-formed command sequences with noise, over several phase lengths and
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [i2cmbs_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [i2cmbs_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int DIRECTED_ROWS = 21;

   typedef struct packed {
      logic [i2cmbs_pkg::OP_W-1:0]   opcode;
      logic [i2cmbs_pkg::BYTE_W-1:0] data_byte;
      logic                          ack_after_read;
      logic                          sda_in;
      logic [4:0]                    reps;
      logic                          typed;
      i2cmbs_pkg::rsp_beat_type      want;
   } stim_row_type;

   // scl, sda, busy, done, read_byte, slave_acked, command_rejected
   localparam i2cmbs_pkg::rsp_beat_type RSP_IDLE_BUS  =
      '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
   localparam i2cmbs_pkg::rsp_beat_type RSP_START_P0  =
      '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
   localparam i2cmbs_pkg::rsp_beat_type RSP_START_REJ =
      '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};
   localparam i2cmbs_pkg::rsp_beat_type RSP_NONE      = '0;

   // phase length is one tick throughout this table
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 5'd1,  1'b1, RSP_IDLE_BUS},
      '{OP_UNUSED_LO,         8'h00, 1'b0, 1'b1, 5'd1,  1'b1, RSP_IDLE_BUS},
      '{OP_UNUSED_HI,         8'hFF, 1'b1, 1'b1, 5'd1,  1'b1, RSP_IDLE_BUS},
      '{i2cmbs_pkg::OP_START, 8'h00, 1'b0, 1'b0, 5'd1,  1'b1, RSP_START_P0},
      '{i2cmbs_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b0, 5'd1,  1'b1, RSP_START_REJ},
      '{OP_UNUSED_HI,         8'h00, 1'b0, 1'b0, 5'd1,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 5'd4,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b0, 5'd1,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_READ,  8'h00, 1'b1, 1'b0, 5'd1,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 5'd17, 1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 5'd1,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 5'd1,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_READ,  8'h00, 1'b1, 1'b0, 5'd1,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 5'd19, 1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_READ,  8'hFF, 1'b0, 1'b0, 5'd1,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 5'd19, 1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_WRITE, 8'h00, 1'b0, 1'b0, 5'd1,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 5'd19, 1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_STOP,  8'h00, 1'b0, 1'b0, 5'd1,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 5'd4,  1'b0, RSP_NONE},
      '{i2cmbs_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 5'd1,  1'b1, RSP_IDLE_BUS}
   };

   logic clock;
   logic reset;

   i2cmbs_req_if req_bus ();
   i2cmbs_rsp_if rsp_bus ();
   i2cmbs_csr_if csr_bus ();

   i2c_master_bit_sequencer_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // bus sequencer shadow state
   logic [i2cmbs_pkg::TICK_W-1:0]  phase_len;
   logic [i2cmbs_pkg::OP_W-1:0]    seq_cmd;
   logic [i2cmbs_pkg::PHASE_W-1:0] seq_phase;
   logic [i2cmbs_pkg::TICK_W-1:0]  seq_ticks;
   logic [i2cmbs_pkg::BYTE_W-1:0]  seq_shift;
   logic                           seq_ack_choice;
   logic                           seq_ack_seen;
   logic                           seq_scl;
   logic                           seq_sda;

   i2cmbs_pkg::rsp_beat_type pin_status_q [$];
   i2cmbs_pkg::rsp_beat_type got_beat;
   i2cmbs_pkg::rsp_beat_type want_beat;

   int mismatches = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   function automatic void reset_sequencer_state();
      phase_len      = i2cmbs_pkg::PHASE_TICKS_RESET;
      seq_cmd        = i2cmbs_pkg::OP_IDLE;
      seq_phase      = '0;
      seq_ticks      = '0;
      seq_shift      = '0;
      seq_ack_choice = 1'b0;
      seq_ack_seen   = 1'b0;
      seq_scl        = 1'b1;
      seq_sda        = 1'b1;
   endfunction

   function automatic void set_phase_levels(input logic [i2cmbs_pkg::OP_W-1:0] cmd,
                                            input logic [i2cmbs_pkg::PHASE_W-1:0] ph);
      logic scl_n;
      logic sda_n;
      scl_n = 1'b0;
      sda_n = seq_sda;
      case (cmd)
         i2cmbs_pkg::OP_START: begin
            scl_n = ph[0] ^ ph[1];
            sda_n = ~ph[1];
         end
         i2cmbs_pkg::OP_STOP: begin
            // first stop phase keeps SDA where it was
            scl_n = ph[1];
            if (ph[1:0] != 2'd0) sda_n = (ph[1:0] == 2'd3);
         end
         i2cmbs_pkg::OP_WRITE, i2cmbs_pkg::OP_READ: begin
            scl_n = ph[0];
            if (ph < i2cmbs_pkg::BYTE_PHASES) begin
               sda_n = (cmd == i2cmbs_pkg::OP_WRITE) ? seq_shift[3'd7 - ph[3:1]] : 1'b1;
            end else if (ph <= i2cmbs_pkg::ACK_HIGH_PHASE) begin
               sda_n = (cmd == i2cmbs_pkg::OP_WRITE) ? 1'b1 : ~seq_ack_choice;
            end else begin
               scl_n = 1'b0;
               sda_n = 1'b1;
            end
         end
         default: ;
      endcase
      seq_scl = scl_n;
      seq_sda = sda_n;
   endfunction

   function automatic i2cmbs_pkg::rsp_beat_type predict_pins(
      input i2cmbs_pkg::req_beat_type b);
      i2cmbs_pkg::rsp_beat_type       r;
      logic [i2cmbs_pkg::TICK_W:0]    lim;
      logic [i2cmbs_pkg::TICK_W:0]    cnt;
      logic [i2cmbs_pkg::PHASE_W-1:0] last;
      logic [i2cmbs_pkg::OP_W-1:0]    cmd;
      r = '0;
      cmd = seq_cmd;
      last = (cmd == i2cmbs_pkg::OP_WRITE || cmd == i2cmbs_pkg::OP_READ) ?
             i2cmbs_pkg::LONG_LAST_PHASE : i2cmbs_pkg::SHORT_LAST_PHASE;
      if (b.opcode >= i2cmbs_pkg::OP_START && b.opcode <= i2cmbs_pkg::OP_READ) begin
         if (cmd != i2cmbs_pkg::OP_IDLE) begin
            r.command_rejected = 1'b1;
         end else begin
            seq_cmd   = b.opcode;
            seq_phase = '0;
            seq_ticks = '0;
            if (b.opcode == i2cmbs_pkg::OP_WRITE) begin
               seq_shift    = b.data_byte;
               seq_ack_seen = 1'b0;
            end else if (b.opcode == i2cmbs_pkg::OP_READ) begin
               seq_shift      = '0;
               seq_ack_choice = b.ack_after_read;
            end
            set_phase_levels(b.opcode, '0);
         end
      end else if (b.opcode == i2cmbs_pkg::OP_TICK && cmd != i2cmbs_pkg::OP_IDLE) begin
         lim = (phase_len == '0) ? 17'd1 : {1'b0, phase_len};
         cnt = {1'b0, seq_ticks} + 17'd1;
         if (cnt >= lim) begin
            seq_ticks = '0;
            if (cmd == i2cmbs_pkg::OP_WRITE && seq_phase == i2cmbs_pkg::ACK_HIGH_PHASE)
               seq_ack_seen = ~b.sda_in;
            if (cmd == i2cmbs_pkg::OP_READ && seq_phase < i2cmbs_pkg::BYTE_PHASES &&
                seq_phase[0])
               seq_shift = {seq_shift[i2cmbs_pkg::BYTE_W-2:0], b.sda_in};
            if (seq_phase == last) begin
               // go idle, pins hold their levels
               seq_cmd    = i2cmbs_pkg::OP_IDLE;
               seq_phase  = '0;
               r.done_res = 1'b1;
               if (cmd == i2cmbs_pkg::OP_READ) r.read_byte = seq_shift;
            end else begin
               seq_phase = seq_phase + 5'd1;
               set_phase_levels(cmd, seq_phase);
            end
         end else begin
            seq_ticks = cnt[i2cmbs_pkg::TICK_W-1:0];
         end
      end
      r.scl_level   = seq_scl;
      r.sda_level   = seq_sda;
      r.busy_res    = (seq_cmd != i2cmbs_pkg::OP_IDLE);
      r.slave_acked = seq_ack_seen;
      return r;
   endfunction

   // mostly whole command sequences; rejected commands and unused opcodes as noise
   function automatic i2cmbs_pkg::req_beat_type random_beat();
      i2cmbs_pkg::req_beat_type b;
      int roll;
      b.data_byte      = 8'($urandom);
      b.ack_after_read = 1'($urandom);
      b.sda_in         = 1'($urandom);
      roll = int'($urandom_range(99));
      if (seq_cmd == i2cmbs_pkg::OP_IDLE) begin
         if (roll < 85)
            b.opcode = 3'($urandom_range(i2cmbs_pkg::OP_READ, i2cmbs_pkg::OP_START));
         else if (roll < 95) b.opcode = i2cmbs_pkg::OP_TICK;
         else b.opcode = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end else begin
         if (roll < 92) b.opcode = i2cmbs_pkg::OP_TICK;
         else if (roll < 96)
            b.opcode = 3'($urandom_range(i2cmbs_pkg::OP_READ, i2cmbs_pkg::OP_START));
         else b.opcode = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end
      return b;
   endfunction

   task automatic send_beat(input i2cmbs_pkg::req_beat_type b, input bit typed,
                            input i2cmbs_pkg::rsp_beat_type typed_want);
      i2cmbs_pkg::rsp_beat_type p;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.opcode         <= b.opcode;
      req_bus.data_byte      <= b.data_byte;
      req_bus.ack_after_read <= b.ack_after_read;
      req_bus.sda_in         <= b.sda_in;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      p = predict_pins(b);
      pin_status_q.push_back(typed ? typed_want : p);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pin_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_phase_len(input logic [i2cmbs_pkg::TICK_W-1:0] len);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= len;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      phase_len = len;
   endtask

   task automatic run_phase(input logic [i2cmbs_pkg::TICK_W-1:0] len, input int sender_idle,
                            input int receiver_stall, input int n_beats,
                            input bit long_hold, input bit start_only);
      i2cmbs_pkg::req_beat_type b;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      write_phase_len(len);
      if (long_hold) hold_req++;
      if (start_only) begin
         // a few ticks into a long phase, then shorten the phase to finish
         b = '{i2cmbs_pkg::OP_START, 8'h00, 1'b0, 1'b0};
         send_beat(b, 1'b0, RSP_NONE);
         repeat (n_beats) begin
            b = '{i2cmbs_pkg::OP_TICK, 8'h00, 1'b0, 1'($urandom)};
            send_beat(b, 1'b0, RSP_NONE);
         end
         drain_results();
         write_phase_len(16'd1);
      end else begin
         repeat (n_beats) send_beat(random_beat(), 1'b0, RSP_NONE);
      end
      // finish the open sequence with ticks only
      while (seq_cmd != i2cmbs_pkg::OP_IDLE) begin
         b = '{i2cmbs_pkg::OP_TICK, 8'h00, 1'b0, 1'($urandom)};
         send_beat(b, 1'b0, RSP_NONE);
      end
      drain_results();
   endtask

   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_left = HOLD_CYCLES;
         hold_seen = hold_req;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_beat = '{rsp_bus.scl_level, rsp_bus.sda_level, rsp_bus.busy_res,
                      rsp_bus.done_res, rsp_bus.read_byte, rsp_bus.slave_acked,
                      rsp_bus.command_rejected};
         if (pin_status_q.size() == 0) begin
            $display("%0t ns: unexpected result beat, expected none, got %p",
                     $time, got_beat);
            mismatches++;
         end else begin
            want_beat = pin_status_q.pop_front();
            if (got_beat !== want_beat) begin
               $display("%0t ns: result beat expected %p, got %p",
                        $time, want_beat, got_beat);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long without any beat moving on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** i2c_master_bit_sequencer_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      i2cmbs_pkg::req_beat_type b;
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.opcode         = i2cmbs_pkg::OP_TICK;
      req_bus.data_byte      = '0;
      req_bus.ack_after_read = 1'b0;
      req_bus.sda_in         = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.data           = '0;
      reset_sequencer_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         b = '{DIRECTED[i].opcode, DIRECTED[i].data_byte, DIRECTED[i].ack_after_read,
               DIRECTED[i].sda_in};
         repeat (DIRECTED[i].reps) send_beat(b, DIRECTED[i].typed, DIRECTED[i].want);
      end
      drain_results();

      run_phase(16'd1, 0, 0, 250, 1'b0, 1'b0);
      run_phase(16'd2, 56, 0, 350, 1'b0, 1'b0);
      // zero phase length behaves as one tick
      run_phase(16'd0, 0, 56, 350, 1'b0, 1'b0);
      run_phase(16'd3, 28, 28, 350, 1'b0, 1'b0);
      run_phase(16'd1, 0, 0, 250, 1'b1, 1'b0);
      run_phase(16'hFFFF, 0, 0, 40, 1'b0, 1'b1);
      run_phase(16'd5, 28, 28, 100, 1'b0, 1'b0);

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("** i2c_master_bit_sequencer_core: PASSED **");
      end else begin
         $display("** i2c_master_bit_sequencer_core: FAILED **");
      end
      $finish;
   end
endmodule

[i2c_master_bit_sequencer_core.f]
rtl/i2cmbs_pkg.sv
rtl/i2cmbs_if.sv
rtl/i2cmbs_in_stage.sv
rtl/i2cmbs_engine.sv
rtl/i2cmbs_out_stage.sv
rtl/i2c_master_bit_sequencer_core.sv
dv/testbench.sv
